FILE: hdl/tftp_transfer_controller_defines.svh
//------------------------------------------------------------------------------
// TFTP transfer controller assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
//------------------------------------------------------------------------------
`ifndef TFTP_TRANSFER_CONTROLLER_DEFINES_SVH
`define TFTP_TRANSFER_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define TFTP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TFTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tftp_pkg.sv
//------------------------------------------------------------------------------
// tftp_pkg
// Types, codes and constants of the TFTP transfer controller.
//------------------------------------------------------------------------------
`default_nettype none

package tftp_pkg;

    localparam int unsigned BLOCK_BYTES_DEF = 512;

    localparam int unsigned CMD_W = 3;
    localparam int unsigned LEN_W = 10;
    localparam int unsigned OPC_W = 16;
    localparam int unsigned BLK_W = 16;
    localparam int unsigned RTY_W = 4;
    localparam int unsigned SOP_W = 3;
    localparam int unsigned ERR_W = 3;
    localparam int unsigned STS_W = 3;

    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 48;

    localparam logic [RTY_W-1:0] RETRY_MAX_RST = 4'd5;
    localparam logic [LEN_W-1:0] HDR_BYTES     = 10'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_OPEN_RD = 3'd0,
        CMD_OPEN_WR = 3'd1,
        CMD_PKT     = 3'd2,
        CMD_TIMEOUT = 3'd3,
        CMD_ILLEGAL = 3'd4
    } cmd_t;

    // received opcodes
    localparam logic [OPC_W-1:0] RX_OP_DATA = 16'd3;
    localparam logic [OPC_W-1:0] RX_OP_ACK  = 16'd4;

    // transmitted opcodes
    localparam logic [SOP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [SOP_W-1:0] OP_DATA  = 3'd3;
    localparam logic [SOP_W-1:0] OP_ACK   = 3'd4;
    localparam logic [SOP_W-1:0] OP_ERROR = 3'd5;

    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NOT_FOUND = 3'd1;
    localparam logic [ERR_W-1:0] ERR_NO_CREATE = 3'd2;
    localparam logic [ERR_W-1:0] ERR_ILLEGAL   = 3'd4;

    localparam logic [STS_W-1:0] ST_IDLE    = 3'd0;
    localparam logic [STS_W-1:0] ST_READING = 3'd1;
    localparam logic [STS_W-1:0] ST_WRITING = 3'd2;
    localparam logic [STS_W-1:0] ST_DONE    = 3'd3;
    localparam logic [STS_W-1:0] ST_ABORT   = 3'd4;
    localparam logic [STS_W-1:0] ST_REJECT  = 3'd5;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_READ  = 3'b010,
        MODE_WRITE = 3'b100
    } mode_t;

    typedef struct packed {
        cmd_t             command;
        logic             file_ok;
        logic [LEN_W-1:0] chunk_length;
        logic [OPC_W-1:0] pkt_opcode;
        logic [BLK_W-1:0] pkt_block;
        logic [LEN_W-1:0] pkt_length;
    } item_t;

    typedef struct packed {
        logic             send_valid;
        logic [SOP_W-1:0] send_opcode;
        logic [BLK_W-1:0] send_block;
        logic [LEN_W-1:0] send_length;
        logic [ERR_W-1:0] err_code;
        logic             write_payload;
        logic [LEN_W-1:0] payload_length;
        logic [STS_W-1:0] status;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/tftp_core.sv
//------------------------------------------------------------------------------
// tftp_core
// Session state and combinational event decode of the TFTP transfer controller.
//------------------------------------------------------------------------------
`default_nettype none

module tftp_core
    import tftp_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire item_t            item,
    input  wire logic [RTY_W-1:0] retry_max,
    output result_t               res
);

    localparam int unsigned BB_W = $clog2(BLOCK_BYTES + 1);
    localparam int unsigned CW   = (BB_W > LEN_W) ? BB_W : LEN_W;
    localparam logic [CW-1:0]    BLK_LIM   = CW'(BLOCK_BYTES);
    localparam logic [LEN_W-1:0] BLK_CLAMP = LEN_W'(BLOCK_BYTES);

    mode_t            mode_reg,  mode_next;
    logic [BLK_W-1:0] blk_reg,   blk_next;
    logic [RTY_W-1:0] retry_reg, retry_next;
    logic [LEN_W-1:0] last_reg,  last_next;

    logic [LEN_W-1:0] chunk_c;
    logic [LEN_W-1:0] pay_raw;
    logic             pay_full;
    logic [BLK_W-1:0] blk_inc;
    logic             hdr_ok;

    assign chunk_c  = (CW'(item.chunk_length) > BLK_LIM) ? BLK_CLAMP : item.chunk_length;
    assign pay_raw  = item.pkt_length - HDR_BYTES;
    assign pay_full = CW'(pay_raw) >= BLK_LIM;
    assign blk_inc  = blk_reg + BLK_W'(1);
    assign hdr_ok   = (item.pkt_length >= HDR_BYTES) && (item.pkt_block == blk_reg);

    always_comb
    begin
        mode_next  = mode_reg;
        blk_next   = blk_reg;
        retry_next = retry_reg;
        last_next  = last_reg;
        res        = '0;
        unique case (mode_reg)
            MODE_READ:
            begin
                res.status = ST_READING;
                unique case (item.command)
                    CMD_PKT:
                    begin
                        if (hdr_ok && item.pkt_opcode == RX_OP_ACK)
                        begin
                            if (CW'(last_reg) < BLK_LIM)
                            begin
                                mode_next  = MODE_IDLE;
                                res.status = ST_DONE;
                            end
                            else
                            begin
                                blk_next        = blk_inc;
                                retry_next      = '0;
                                last_next       = chunk_c;
                                res.send_valid  = 1'b1;
                                res.send_opcode = OP_DATA;
                                res.send_block  = blk_inc;
                                res.send_length = chunk_c + HDR_BYTES;
                            end
                        end
                    end
                    CMD_TIMEOUT:
                    begin
                        if (retry_reg < retry_max)
                        begin
                            retry_next      = retry_reg + RTY_W'(1);
                            res.send_valid  = 1'b1;
                            res.send_opcode = OP_DATA;
                            res.send_block  = blk_reg;
                            res.send_length = last_reg + HDR_BYTES;
                        end
                        else
                        begin
                            mode_next  = MODE_IDLE;
                            res.status = ST_ABORT;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            MODE_WRITE:
            begin
                res.status = ST_WRITING;
                unique case (item.command)
                    CMD_PKT:
                    begin
                        if (hdr_ok && item.pkt_opcode == RX_OP_DATA)
                        begin
                            res.send_valid     = 1'b1;
                            res.send_opcode    = OP_ACK;
                            res.send_block     = blk_reg;
                            res.send_length    = HDR_BYTES;
                            res.write_payload  = 1'b1;
                            res.payload_length = pay_full ? BLK_CLAMP : pay_raw;
                            if (pay_full)
                            begin
                                blk_next = blk_inc;
                            end
                            else
                            begin
                                mode_next  = MODE_IDLE;
                                res.status = ST_DONE;
                            end
                        end
                    end
                    CMD_TIMEOUT:
                    begin
                        mode_next  = MODE_IDLE;
                        res.status = ST_ABORT;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                res.status = ST_IDLE;
                unique case (item.command)
                    CMD_OPEN_RD:
                    begin
                        res.send_valid = 1'b1;
                        if (item.file_ok)
                        begin
                            mode_next       = MODE_READ;
                            blk_next        = BLK_W'(1);
                            retry_next      = '0;
                            last_next       = chunk_c;
                            res.send_opcode = OP_DATA;
                            res.send_block  = BLK_W'(1);
                            res.send_length = chunk_c + HDR_BYTES;
                            res.status      = ST_READING;
                        end
                        else
                        begin
                            res.send_opcode = OP_ERROR;
                            res.err_code    = ERR_NOT_FOUND;
                            res.status      = ST_REJECT;
                        end
                    end
                    CMD_OPEN_WR:
                    begin
                        res.send_valid = 1'b1;
                        if (item.file_ok)
                        begin
                            mode_next       = MODE_WRITE;
                            blk_next        = BLK_W'(1);
                            retry_next      = '0;
                            res.send_opcode = OP_ACK;
                            res.send_length = HDR_BYTES;
                            res.status      = ST_WRITING;
                        end
                        else
                        begin
                            res.send_opcode = OP_ERROR;
                            res.err_code    = ERR_NO_CREATE;
                            res.status      = ST_REJECT;
                        end
                    end
                    CMD_ILLEGAL:
                    begin
                        res.send_valid  = 1'b1;
                        res.send_opcode = OP_ERROR;
                        res.err_code    = ERR_ILLEGAL;
                        res.status      = ST_REJECT;
                    end
                    default:
                    begin
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            blk_reg   <= '0;
            retry_reg <= '0;
            last_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            blk_reg   <= blk_next;
            retry_reg <= retry_next;
            last_reg  <= last_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tftp_transfer_controller.sv
//------------------------------------------------------------------------------
// tftp_transfer_controller
// Stop-and-wait TFTP session controller, one event item in, one result item out.
//
//  channel  dir  handshake                tdata / tuser
//  s_axis   in   s_tvalid / s_tready      event fields / command
//  m_axis   out  m_tvalid / m_tready      result fields
//  cfg      in   cfg_valid / cfg_ready    retry limit
//
//  One item per cycle sustained while m_tready is high; an input register and a
//  result register, the event decode sits between them.
//  Reset: session idle, retry limit 5, both stages empty.
//  A stalled result holds the input stage; s_tready drops only when both are full.
//  cfg_ready is always high.
//------------------------------------------------------------------------------
`default_nettype none

`include "tftp_transfer_controller_defines.svh"

module tftp_transfer_controller
    import tftp_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // file_ok, chunk_length, pkt_opcode, pkt_block, pkt_length, zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // command
    input  wire logic [CMD_W-1:0]     s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // send_valid, send_opcode, send_block, send_length, err_code,
    // write_payload, payload_length, status, zero pad
    output logic [M_TDATA_W-1:0]      m_tdata,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [RTY_W-1:0]     cfg_data
);

    logic             in_valid_reg;
    item_t            in_item_reg;
    logic             out_valid_reg;
    result_t          out_res_reg;
    logic [RTY_W-1:0] retry_max_reg;
    logic             advance;
    item_t            s_item;
    result_t          core_res;

    assign s_item.command      = cmd_t'(s_tuser);
    assign s_item.file_ok      = s_tdata[0];
    assign s_item.chunk_length = s_tdata[10:1];
    assign s_item.pkt_opcode   = s_tdata[26:11];
    assign s_item.pkt_block    = s_tdata[42:27];
    assign s_item.pkt_length   = s_tdata[52:43];

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_res_reg.status, out_res_reg.payload_length,
                        out_res_reg.write_payload, out_res_reg.err_code,
                        out_res_reg.send_length, out_res_reg.send_block,
                        out_res_reg.send_opcode, out_res_reg.send_valid};

    tftp_core #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (in_item_reg),
        .retry_max   (retry_max_reg),
        .res         (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            retry_max_reg <= RETRY_MAX_RST;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                retry_max_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= s_item;
        end
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    `TFTP_ASSERT_SAME(a_wr_is_ack, out_valid_reg && out_res_reg.write_payload, out_res_reg.send_opcode == OP_ACK, "payload write without ACK")
    `TFTP_ASSERT_SAME(a_err_is_error, out_valid_reg && (out_res_reg.err_code != ERR_NONE), out_res_reg.send_opcode == OP_ERROR, "error code outside ERROR")
    `TFTP_ASSERT_SAME(a_nosend_clear, out_valid_reg && !out_res_reg.send_valid, out_res_reg.send_opcode == OP_NONE, "opcode set with no send")
    `TFTP_ASSERT_NEXT(a_stall_holds, in_valid_reg && out_valid_reg && !m_tready, in_valid_reg && out_valid_reg, "stalled item dropped")
    `TFTP_ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready && !advance, in_valid_reg, "accepted item lost")

endmodule

`default_nettype wire

FILE: sim/tb.sv
//------------------------------------------------------------------------------
// tb: TFTP transfer controller testbench
// Drives session events through the input stream and checks every result item
// against a built-in session predictor or a typed row's expected result. A
// directed table covers rejects, busy and idle events, runt and mismatched
// packets, saturation, abort. Random sessions run under several retry limits,
// then a short random tail. Both stream sides insert random gaps and stalls.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import tftp_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned ITEMS_PER_SET  = 165;
    localparam cmd_t        CMD_SPARE      = cmd_t'(3'd7);
    localparam logic [LEN_W-1:0] FULL_LEN  = 10'(BLOCK_BYTES_DEF);

    typedef struct {
        bit      typed;
        item_t   stim;
        result_t want;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [RTY_W-1:0]     cfg_data = '0;

    // session predictor state
    mode_t            sess_mode = MODE_IDLE;
    logic [BLK_W-1:0] next_block = '0;
    logic [RTY_W-1:0] timeouts_seen = '0;
    logic [LEN_W-1:0] cur_chunk = '0;
    logic [RTY_W-1:0] retry_limit = RETRY_MAX_RST;
    bit               heavy_timeouts = 1'b0;

    result_t     pending_results[$];
    int unsigned errors = 0;
    int unsigned idle_cycles = 0;
    bit          nogap = 1'b0;
    logic [RTY_W-1:0] limit_plan [5] = '{4'd0, 4'd15, 4'd0, 4'd1, 4'd15};

    dir_row_t dir_rows [25] = '{
        '{1'b1, item_t'{CMD_ILLEGAL, 1'b0, 10'd0, 16'd0, 16'd0, 10'd0},
            result_t'{1'b1, OP_ERROR, 16'd0, 10'd0, ERR_ILLEGAL, 1'b0, 10'd0, ST_REJECT}},
        '{1'b1, item_t'{CMD_OPEN_RD, 1'b0, 10'd1023, 16'hFFFF, 16'hFFFF, 10'd1023},
            result_t'{1'b1, OP_ERROR, 16'd0, 10'd0, ERR_NOT_FOUND, 1'b0, 10'd0, ST_REJECT}},
        '{1'b1, item_t'{CMD_OPEN_WR, 1'b0, 10'd0, 16'd0, 16'd0, 10'd0},
            result_t'{1'b1, OP_ERROR, 16'd0, 10'd0, ERR_NO_CREATE, 1'b0, 10'd0, ST_REJECT}},
        '{1'b1, item_t'{CMD_PKT, 1'b1, 10'd0, RX_OP_ACK, 16'd0, 10'd4},
            result_t'{1'b0, OP_NONE, 16'd0, 10'd0, ERR_NONE, 1'b0, 10'd0, ST_IDLE}},
        '{1'b1, item_t'{CMD_TIMEOUT, 1'b1, 10'd0, 16'd0, 16'd0, 10'd0},
            result_t'{1'b0, OP_NONE, 16'd0, 10'd0, ERR_NONE, 1'b0, 10'd0, ST_IDLE}},
        '{1'b1, item_t'{CMD_SPARE, 1'b1, 10'd1023, 16'hFFFF, 16'hFFFF, 10'd1023},
            result_t'{1'b0, OP_NONE, 16'd0, 10'd0, ERR_NONE, 1'b0, 10'd0, ST_IDLE}},
        '{1'b1, item_t'{CMD_OPEN_RD, 1'b1, 10'd1023, 16'd0, 16'd0, 10'd0},
            result_t'{1'b1, OP_DATA, 16'd1, 10'd516, ERR_NONE, 1'b0, 10'd0, ST_READING}},
        '{1'b1, item_t'{CMD_OPEN_WR, 1'b1, 10'd0, 16'd0, 16'd0, 10'd0},
            result_t'{1'b0, OP_NONE, 16'd0, 10'd0, ERR_NONE, 1'b0, 10'd0, ST_READING}},
        '{1'b1, item_t'{CMD_ILLEGAL, 1'b1, 10'd0, 16'd0, 16'd0, 10'd0},
            result_t'{1'b0, OP_NONE, 16'd0, 10'd0, ERR_NONE, 1'b0, 10'd0, ST_READING}},
        '{1'b0, item_t'{CMD_PKT, 1'b0, 10'd0, RX_OP_ACK, 16'd2, 10'd4}, '0},
        '{1'b0, item_t'{CMD_PKT, 1'b0, 10'd0, RX_OP_ACK, 16'd1, 10'd3}, '0},
        '{1'b0, item_t'{CMD_PKT, 1'b0, 10'd0, RX_OP_DATA, 16'd1, 10'd4}, '0},
        '{1'b1, item_t'{CMD_TIMEOUT, 1'b0, 10'd0, 16'd0, 16'd0, 10'd0},
            result_t'{1'b1, OP_DATA, 16'd1, 10'd516, ERR_NONE, 1'b0, 10'd0, ST_READING}},
        '{1'b1, item_t'{CMD_PKT, 1'b0, 10'd0, RX_OP_ACK, 16'd1, 10'd4},
            result_t'{1'b1, OP_DATA, 16'd2, 10'd4, ERR_NONE, 1'b0, 10'd0, ST_READING}},
        '{1'b1, item_t'{CMD_PKT, 1'b0, 10'd0, RX_OP_ACK, 16'd2, 10'd1023},
            result_t'{1'b0, OP_NONE, 16'd0, 10'd0, ERR_NONE, 1'b0, 10'd0, ST_DONE}},
        '{1'b1, item_t'{CMD_OPEN_WR, 1'b1, 10'd0, 16'd0, 16'd0, 10'd0},
            result_t'{1'b1, OP_ACK, 16'd0, 10'd4, ERR_NONE, 1'b0, 10'd0, ST_WRITING}},
        '{1'b1, item_t'{CMD_PKT, 1'b0, 10'd0, RX_OP_DATA, 16'd1, 10'd1023},
            result_t'{1'b1, OP_ACK, 16'd1, 10'd4, ERR_NONE, 1'b1, 10'd512, ST_WRITING}},
        '{1'b0, item_t'{CMD_PKT, 1'b0, 10'd0, RX_OP_ACK, 16'd2, 10'd4}, '0},
        '{1'b0, item_t'{CMD_PKT, 1'b0, 10'd0, RX_OP_DATA, 16'd1, 10'd100}, '0},
        '{1'b0, item_t'{CMD_PKT, 1'b0, 10'd0, RX_OP_DATA, 16'd2, 10'd3}, '0},
        '{1'b1, item_t'{CMD_PKT, 1'b0, 10'd0, RX_OP_DATA, 16'd2, 10'd4},
            result_t'{1'b1, OP_ACK, 16'd2, 10'd4, ERR_NONE, 1'b1, 10'd0, ST_DONE}},
        '{1'b0, item_t'{CMD_OPEN_WR, 1'b1, 10'd0, 16'd0, 16'd0, 10'd0}, '0},
        '{1'b1, item_t'{CMD_TIMEOUT, 1'b0, 10'd0, 16'd0, 16'd0, 10'd0},
            result_t'{1'b0, OP_NONE, 16'd0, 10'd0, ERR_NONE, 1'b0, 10'd0, ST_ABORT}},
        '{1'b0, item_t'{CMD_OPEN_RD, 1'b1, 10'd511, 16'd0, 16'd0, 10'd0}, '0},
        '{1'b0, item_t'{CMD_PKT, 1'b0, 10'd0, RX_OP_ACK, 16'd1, 10'd516}, '0}
    };

    tftp_transfer_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [LEN_W-1:0] fit_block(input logic [LEN_W-1:0] len);
        return (len > FULL_LEN) ? FULL_LEN : len;
    endfunction

    function automatic result_t block_out();
        result_t r;
        r = '0;
        r.send_valid  = 1'b1;
        r.send_opcode = OP_DATA;
        r.send_block  = next_block;
        r.send_length = cur_chunk + HDR_BYTES;
        return r;
    endfunction

    function automatic result_t step_session(input item_t it);
        result_t          r;
        logic [LEN_W-1:0] pay;
        bit               full;
        r = '0;
        if (sess_mode == MODE_IDLE) begin
            r.status = ST_IDLE;
            if (it.command == CMD_OPEN_RD && it.file_ok) begin
                sess_mode     = MODE_READ;
                next_block    = 16'd1;
                timeouts_seen = '0;
                cur_chunk     = fit_block(it.chunk_length);
                r             = block_out();
                r.status      = ST_READING;
            end else if (it.command == CMD_OPEN_WR && it.file_ok) begin
                sess_mode     = MODE_WRITE;
                next_block    = 16'd1;
                timeouts_seen = '0;
                r.send_valid  = 1'b1;
                r.send_opcode = OP_ACK;
                r.send_length = HDR_BYTES;
                r.status      = ST_WRITING;
            end else if (it.command == CMD_OPEN_RD || it.command == CMD_OPEN_WR
                         || it.command == CMD_ILLEGAL) begin
                r.send_valid  = 1'b1;
                r.send_opcode = OP_ERROR;
                r.err_code    = (it.command == CMD_OPEN_RD) ? ERR_NOT_FOUND :
                                (it.command == CMD_OPEN_WR) ? ERR_NO_CREATE : ERR_ILLEGAL;
                r.status      = ST_REJECT;
            end
        end else if (sess_mode == MODE_READ) begin
            r.status = ST_READING;
            if (it.command == CMD_PKT) begin
                if (it.pkt_length >= HDR_BYTES && it.pkt_opcode == RX_OP_ACK
                    && it.pkt_block == next_block) begin
                    if (cur_chunk < FULL_LEN) begin
                        sess_mode = MODE_IDLE;
                        r.status  = ST_DONE;
                    end else begin
                        next_block    = next_block + 16'd1;
                        timeouts_seen = '0;
                        cur_chunk     = fit_block(it.chunk_length);
                        r             = block_out();
                        r.status      = ST_READING;
                    end
                end
            end else if (it.command == CMD_TIMEOUT) begin
                if (timeouts_seen < retry_limit) begin
                    timeouts_seen = timeouts_seen + 4'd1;
                    r             = block_out();
                    r.status      = ST_READING;
                end else begin
                    sess_mode = MODE_IDLE;
                    r.status  = ST_ABORT;
                end
            end
        end else begin
            r.status = ST_WRITING;
            if (it.command == CMD_PKT) begin
                if (it.pkt_length >= HDR_BYTES && it.pkt_opcode == RX_OP_DATA
                    && it.pkt_block == next_block) begin
                    pay  = it.pkt_length - HDR_BYTES;
                    full = (pay >= FULL_LEN);
                    r.send_valid     = 1'b1;
                    r.send_opcode    = OP_ACK;
                    r.send_block     = next_block;
                    r.send_length    = HDR_BYTES;
                    r.write_payload  = 1'b1;
                    r.payload_length = full ? FULL_LEN : pay;
                    if (full) begin
                        next_block = next_block + 16'd1;
                    end else begin
                        sess_mode = MODE_IDLE;
                        r.status  = ST_DONE;
                    end
                end
            end else if (it.command == CMD_TIMEOUT) begin
                sess_mode = MODE_IDLE;
                r.status  = ST_ABORT;
            end
        end
        return r;
    endfunction

    // mostly well-formed session traffic, the rest near misses and noise
    function automatic item_t make_event();
        item_t       it;
        int unsigned pick;
        int unsigned ack_pct;
        int unsigned to_pct;
        it.command      = cmd_t'($urandom_range(0, 7));
        it.file_ok      = 1'($urandom_range(0, 1));
        it.chunk_length = 10'($urandom_range(0, 1023));
        it.pkt_opcode   = 16'($urandom);
        it.pkt_block    = 16'($urandom);
        it.pkt_length   = 10'($urandom_range(0, 1023));
        pick            = $urandom_range(0, 99);
        ack_pct         = heavy_timeouts ? 5 : 70;
        to_pct          = heavy_timeouts ? 95 : 82;
        if (sess_mode == MODE_IDLE) begin
            if (pick < 80) begin
                it.command   = pick[0] ? CMD_OPEN_WR : CMD_OPEN_RD;
                it.file_ok   = (pick < 72);
                if ($urandom_range(0, 99) < 85)
                    it.chunk_length = 10'($urandom_range(512, 1023));
                heavy_timeouts = ($urandom_range(0, 4) == 0);
            end
        end else if (sess_mode == MODE_READ) begin
            if (pick < ack_pct || pick % 3 == 1) begin
                it.command    = CMD_PKT;
                it.pkt_opcode = RX_OP_ACK;
                it.pkt_block  = next_block;
                it.pkt_length = (pick < ack_pct) ? 10'($urandom_range(4, 1023))
                                                 : 10'($urandom_range(0, 3));
                if ($urandom_range(0, 99) < 85)
                    it.chunk_length = 10'($urandom_range(512, 1023));
            end else if (pick < to_pct) begin
                it.command = CMD_TIMEOUT;
            end else if (pick % 3 == 0) begin
                it.command    = CMD_PKT;
                it.pkt_opcode = RX_OP_ACK;
                it.pkt_block  = next_block + 16'd1;
            end
        end else begin
            if (pick < 75 || pick % 3 == 1) begin
                it.command    = CMD_PKT;
                it.pkt_opcode = RX_OP_DATA;
                it.pkt_block  = next_block;
                if (pick >= 75)
                    it.pkt_length = 10'($urandom_range(0, 3));
                else if ($urandom_range(0, 99) < 85)
                    it.pkt_length = 10'($urandom_range(516, 1023));
                else
                    it.pkt_length = 10'($urandom_range(4, 515));
            end else if (pick < 78) begin
                it.command = CMD_TIMEOUT;
            end else if (pick % 3 == 0) begin
                it.command    = CMD_PKT;
                it.pkt_opcode = RX_OP_DATA;
                it.pkt_block  = next_block - 16'd1;
            end
        end
        return it;
    endfunction

    task automatic send_event(input item_t it, input bit typed, input result_t want);
        int unsigned gap;
        result_t     predicted;
        gap = nogap ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.command;
        s_tdata  <= {3'b000, it.pkt_length, it.pkt_block, it.pkt_opcode,
                     it.chunk_length, it.file_ok};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predicted = step_session(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [RTY_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid   <= 1'b0;
        retry_limit = value;
    endtask

    task automatic check_field(input string fld, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, fld, want, got);
        end
    endtask

    initial
    begin
        int unsigned stall;
        forever begin
            stall = nogap ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result item with none expected, got %h", $time, m_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("send_valid", want.send_valid, m_tdata[0]);
                check_field("send_opcode", want.send_opcode, m_tdata[3:1]);
                check_field("send_block", want.send_block, m_tdata[19:4]);
                check_field("send_length", want.send_length, m_tdata[29:20]);
                check_field("err_code", want.err_code, m_tdata[32:30]);
                check_field("write_payload", want.write_payload, m_tdata[33]);
                check_field("payload_length", want.payload_length, m_tdata[43:34]);
                check_field("status", want.status, m_tdata[46:44]);
            end
        end
    end

    initial
    begin
        limit_plan[2] = 4'($urandom_range(1, 14));
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_event(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

        foreach (limit_plan[p]) begin
            wait_idle();
            write_limit(limit_plan[p]);
            for (int i = 0; i < ITEMS_PER_SET; i++) begin
                nogap = (i % 80) < 20;
                if (i % 97 == 96)
                    wait_idle();
                send_event(make_event(), 1'b0, '0);
            end
        end

        nogap = 1'b0;
        for (int i = 0; i < 40; i++)
            send_event(make_event(), 1'b0, '0);

        wait_idle();
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/tftp_pkg.sv
hdl/tftp_core.sv
hdl/tftp_transfer_controller.sv
sim/tb.sv
